[rtl/cidr_pkg.sv]
// Package for the IPv4 CIDR text parser: character codes, limits and widths.
// No dependencies; used by rtl/ipv4_cidr_text_parser.sv.
package cidr_pkg;

   // widths
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned FieldWidth = 9;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned AddrWidth  = 32;
   localparam int unsigned DigitWidth = 12;  // field * 10 + 9 fits here

   // character codes
   localparam logic [CharWidth-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CharWidth-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CharWidth-1:0] CHAR_SLASH = 8'h2F;

   // limits
   localparam logic [FieldWidth-1:0] OCTET_MAX  = 9'd255;
   localparam logic [FieldWidth-1:0] PREFIX_MAX = 9'd32;
   localparam logic [FieldWidth-1:0] FIELD_SAT  = 9'd256;
   localparam logic [CountWidth-1:0] DOTS_FULL  = 3'd3;
   localparam logic [CountWidth-1:0] SLASH_SEEN = 3'd4;

   // prefix length to network mask; zero length gives an all-zero mask
   function automatic logic [AddrWidth-1:0] prefix_mask(input logic [5:0] len);
      prefix_mask = ~({AddrWidth{1'b1}} >> len);
   endfunction

endpackage

[rtl/ipv4_cidr_text_parser.sv]
// Top level of the IPv4 CIDR text parser: one ASCII character per beat in,
// one address/invalid result per NUL out. Depends on rtl/cidr_pkg.sv.
//
//   channel | direction | tdata                     | tuser
//   req     | in        | [7:0] char_code           | -
//   rsp     | out       | [31:0] network_address    | [0] invalid
//
// One character per cycle sustained while no NUL waits. A beat is captured
// in the input register, the parse state is updated from that register, and
// a NUL loads the result register. A NUL waits in the input register only
// while the result register is full and stalled; others never wait.
// Synchronous active-high reset clears the parse state and both valid flags.
module ipv4_cidr_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] network_address
   output logic [0:0]  rsp_tuser    // [0] invalid
);

   // input register
   logic                               in_valid_ff, in_valid_in;
   logic [cidr_pkg::CharWidth-1:0]     char_ff, char_in;

   // parse state
   logic [cidr_pkg::FieldWidth-1:0]    field_value_ff, field_value_in;
   logic [cidr_pkg::CountWidth-1:0]    field_count_ff, field_count_in;
   logic [cidr_pkg::AddrWidth-1:0]     address_acc_ff, address_acc_in;
   logic                               error_seen_ff, error_seen_in;

   // result register
   logic                               out_valid_ff, out_valid_in;
   logic [cidr_pkg::AddrWidth-1:0]     out_addr_ff, out_addr_in;
   logic                               out_bad_ff, out_bad_in;

   logic                               is_nul, is_digit, sep_ok;
   logic                               out_free, consume;
   logic [cidr_pkg::DigitWidth-1:0]    digit_sum;
   logic [cidr_pkg::AddrWidth-1:0]     shifted_acc;
   logic [cidr_pkg::AddrWidth-1:0]     end_addr;
   logic                               end_bad;

   // character decode
   assign is_nul   = (char_ff == cidr_pkg::CHAR_NUL);
   assign is_digit = (char_ff >= cidr_pkg::CHAR_ZERO) && (char_ff <= cidr_pkg::CHAR_NINE);
   assign sep_ok   = ((char_ff == cidr_pkg::CHAR_DOT) &&
                      (field_count_ff < cidr_pkg::DOTS_FULL)) ||
                     ((char_ff == cidr_pkg::CHAR_SLASH) &&
                      (field_count_ff == cidr_pkg::DOTS_FULL));

   // handshake: a NUL needs a free result register
   assign out_free   = !out_valid_ff || rsp_tready;
   assign consume    = in_valid_ff && (!is_nul || out_free);
   assign req_tready = !in_valid_ff || consume;

   // field * 10 + digit, and the accumulator with the current field appended
   assign digit_sum = {field_value_ff, 3'b000} + {2'b00, field_value_ff, 1'b0}
                    + {4'b0000, char_ff - cidr_pkg::CHAR_ZERO};
   assign shifted_acc = {address_acc_ff[cidr_pkg::AddrWidth-9:0], 8'h00}
                      + {{(cidr_pkg::AddrWidth-cidr_pkg::FieldWidth){1'b0}},
                         field_value_ff};

   // end-of-string result
   always_comb begin
      end_addr = '0;
      end_bad  = error_seen_ff;
      if (!error_seen_ff) begin
         if ((field_count_ff == cidr_pkg::DOTS_FULL) &&
             (field_value_ff <= cidr_pkg::OCTET_MAX)) begin
            end_addr = shifted_acc;
         end else if ((field_count_ff == cidr_pkg::SLASH_SEEN) &&
                      (field_value_ff <= cidr_pkg::PREFIX_MAX)) begin
            end_addr = address_acc_ff & cidr_pkg::prefix_mask(field_value_ff[5:0]);
         end else begin
            end_bad = 1'b1;
         end
      end
      if (end_bad) begin
         end_addr = '0;
      end
   end

   // next-state logic
   always_comb begin
      in_valid_in    = in_valid_ff;
      char_in        = char_ff;
      field_value_in = field_value_ff;
      field_count_in = field_count_ff;
      address_acc_in = address_acc_ff;
      error_seen_in  = error_seen_ff;
      out_valid_in   = out_valid_ff;
      out_addr_in    = out_addr_ff;
      out_bad_in     = out_bad_ff;

      // result beat taken
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // parse the held character
      if (consume) begin
         in_valid_in = 1'b0;
         if (is_nul) begin
            out_valid_in   = 1'b1;
            out_addr_in    = end_addr;
            out_bad_in     = end_bad;
            field_value_in = '0;
            field_count_in = '0;
            address_acc_in = '0;
            error_seen_in  = 1'b0;
         end else if (!error_seen_ff) begin
            if (is_digit) begin
               if (digit_sum > {3'b000, cidr_pkg::OCTET_MAX}) begin
                  field_value_in = cidr_pkg::FIELD_SAT;
                  error_seen_in  = 1'b1;
               end else begin
                  field_value_in = digit_sum[cidr_pkg::FieldWidth-1:0];
               end
            end else if (sep_ok) begin
               address_acc_in = shifted_acc;
               field_count_in = field_count_ff + 3'd1;
               field_value_in = '0;
            end else begin
               error_seen_in = 1'b1;
            end
         end
      end

      // capture a new character beat
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         char_in     = req_tdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         field_value_ff <= '0;
         field_count_ff <= '0;
         address_acc_ff <= '0;
         error_seen_ff  <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         field_value_ff <= field_value_in;
         field_count_ff <= field_count_in;
         address_acc_ff <= address_acc_in;
         error_seen_ff  <= error_seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      out_addr_ff <= out_addr_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_addr_ff;
   assign rsp_tuser[0] = out_bad_ff;

endmodule

[tb/sv/ipv4_cidr_text_parser_tb.sv]
// Testbench for ipv4_cidr_text_parser: streams address text one character per beat and
// checks every address/invalid result against a local parse of the same text.
// Depends on rtl/cidr_pkg.sv and rtl/ipv4_cidr_text_parser.sv.
`timescale 1ns / 100ps

module ipv4_cidr_text_parser_tb;

   typedef struct packed {
      logic [31:0] addr;
      logic        invalid;
   } cidr_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] network_address
   logic [0:0]  rsp_tuser;           // [0] invalid

   // shadow parse state
   logic [8:0]  field_val;
   logic [2:0]  sep_count;
   logic [31:0] addr_acc;
   logic        err_flag;

   cidr_result_type pending_results[$];
   logic [7:0]      text_buf[$];

   bit idle_on = 1'b1;
   int mismatch_count = 0;
   int results_checked = 0;
   int invalid_seen = 0;
   int chars_sent = 0;
   int strings_sent = 0;

   ipv4_cidr_text_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // mask with len ones at the top; len 0 is all zeros
   function automatic logic [31:0] net_mask(input logic [5:0] len);
      if (len == 6'd0) return 32'h0;
      return 32'hFFFF_FFFF << (6'd32 - len);
   endfunction

   function automatic void clear_parse();
      field_val = '0;
      sep_count = '0;
      addr_acc  = '0;
      err_flag  = 1'b0;
   endfunction

   // advance the shadow parser by one accepted character
   function automatic void parse_char(input logic [7:0] c);
      cidr_result_type r;
      logic [11:0]     next_val;
      if (c == cidr_pkg::CHAR_NUL) begin
         r.addr    = 32'h0;
         r.invalid = err_flag;
         if (!err_flag) begin
            if (sep_count == cidr_pkg::DOTS_FULL && field_val <= cidr_pkg::OCTET_MAX)
               r.addr = (addr_acc << 8) + 32'(field_val);
            else if (sep_count == cidr_pkg::SLASH_SEEN &&
                     field_val <= cidr_pkg::PREFIX_MAX)
               r.addr = addr_acc & net_mask(field_val[5:0]);
            else
               r.invalid = 1'b1;
         end
         if (r.invalid) r.addr = 32'h0;
         pending_results.push_back(r);
         clear_parse();
      end else if (!err_flag) begin
         if (c >= cidr_pkg::CHAR_ZERO && c <= cidr_pkg::CHAR_NINE) begin
            next_val = 12'(field_val) * 12'd10 + 12'(c - cidr_pkg::CHAR_ZERO);
            if (next_val > 12'(cidr_pkg::OCTET_MAX)) begin
               field_val = cidr_pkg::FIELD_SAT;
               err_flag  = 1'b1;
            end else begin
               field_val = next_val[8:0];
            end
         end else if ((c == cidr_pkg::CHAR_DOT && sep_count < cidr_pkg::DOTS_FULL) ||
                      (c == cidr_pkg::CHAR_SLASH && sep_count == cidr_pkg::DOTS_FULL)) begin
            addr_acc  = (addr_acc << 8) + 32'(field_val);
            sep_count = sep_count + 3'd1;
            field_val = '0;
         end else begin
            err_flag = 1'b1;
         end
      end
   endfunction

   // send one character beat, with an optional idle burst first
   task automatic send_char(input logic [7:0] c);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_char(c);
      chars_sent++;
   endtask

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void put_num(input int v);
      put_text($sformatf("%0d", v));
   endfunction

   // send the buffered text followed by the NUL terminator
   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i]);
      send_char(cidr_pkg::CHAR_NUL);
      text_buf.delete();
      strings_sent++;
   endtask

   task automatic send_string(input string s);
      put_text(s);
      send_text();
   endtask

   // hold the sender off until every pending result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // random dotted quad with optional prefix, biased toward the edges
   function automatic void make_address();
      int sel;
      for (int i = 0; i < 4; i++) begin
         if (i > 0) text_buf.push_back(cidr_pkg::CHAR_DOT);
         sel = $urandom_range(0, 19);
         case (sel)
            0: ;                                    // empty octet
            1: begin
               put_text("0");
               put_num($urandom_range(0, 99));
            end
            2: put_num(255);
            3: put_num(0);
            4: put_num($urandom_range(256, 999));  // overflow
            default: put_num($urandom_range(0, 255));
         endcase
      end
      if ($urandom_range(0, 9) >= 4) begin
         text_buf.push_back(cidr_pkg::CHAR_SLASH);
         sel = $urandom_range(0, 9);
         case (sel)
            0: ;                                    // empty prefix
            1: put_num(0);
            2: put_num(32);
            3: put_num($urandom_range(33, 300));
            default: put_num($urandom_range(1, 31));
         endcase
      end
   endfunction

   // damage the string with one random insertion or deletion
   function automatic void damage_text();
      int pos;
      pos = $urandom_range(0, text_buf.size());
      case ($urandom_range(0, 3))
         0: text_buf.insert(pos, 8'($urandom_range(1, 255)));
         1: if (text_buf.size() != 0) text_buf.delete(pos % text_buf.size());
         2: text_buf.insert(pos, cidr_pkg::CHAR_DOT);
         default: text_buf.insert(pos, cidr_pkg::CHAR_SLASH);
      endcase
   endfunction

   // result side: random stall bursts and the field checks
   initial begin
      cidr_result_type exp_r;
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (rsp_tuser[0]) invalid_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual addr %h invalid %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               mismatch_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_tdata !== exp_r.addr) begin
                  $display("%0t: network_address expected %h actual %h",
                           $time, exp_r.addr, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== exp_r.invalid) begin
                  $display("%0t: invalid expected %b actual %b",
                           $time, exp_r.invalid, rsp_tuser[0]);
                  mismatch_count++;
               end
               results_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // edges of each field and each malformed form
   task automatic test_directed();
      send_string("0.0.0.0");
      send_string("255.255.255.255");
      send_string("192.168.1.77/24");
      send_string("10.20.30.40/32");
      send_string("10.20.30.40/0");
      send_string("10.20.30.40/");     // empty prefix
      send_string("1..3.");            // empty octets
      send_string("256.1.2.3");        // octet overflow
      send_string("1.2.3.4/33");       // prefix just too long
      send_string("1.2.3.4/2550");     // prefix saturates
      send_string("1.2.3.4.5");        // extra dot
      send_string("1.2/3.4");          // early slash
      send_string("1.2.3.4/8/8");      // second slash
      send_string("1.2.3");            // too few dots
      send_string("");                 // bare NUL
      send_string("12a.1.1.1");        // stray letter
      put_text("1.2.3.");
      text_buf.push_back(8'hFF);
      send_text();
      send_string("007.08.9.010/31");
   endtask

   // random addresses with edge and malformed fields, some damaged
   task automatic test_random_addresses(input int char_budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < char_budget) begin
         make_address();
         if ($urandom_range(0, 9) < 3) damage_text();
         send_text();
      end
   endtask

   // raw byte noise, NUL included
   task automatic test_byte_noise(input int char_budget);
      int start;
      int len;
      start = chars_sent;
      while (chars_sent - start < char_budget) begin
         len = $urandom_range(0, 8);
         repeat (len) begin
            if ($urandom_range(0, 1) == 0)
               text_buf.push_back(8'($urandom_range(0, 255)));
            else
               text_buf.push_back(8'($urandom_range(8'h2E, 8'h39)));
         end
         send_text();
      end
   endtask

   // sender waits for the result of each string before the next
   task automatic test_drain_pause();
      repeat (4) begin
         make_address();
         send_text();
         drain_results();
      end
   endtask

   // back-to-back traffic on both sides
   task automatic test_full_rate(input int char_budget);
      idle_on = 1'b0;
      test_random_addresses(char_budget);
   endtask

   initial begin
      clear_parse();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_addresses(1200);
      test_byte_noise(250);
      test_drain_pause();
      test_full_rate(300);

      drain_results();
      repeat (20) @(posedge clock);

      $display("Sent %0d strings (%0d characters): valid, damaged and noise text.",
               strings_sent, chars_sent);
      $display("Checked %0d results, %0d of them invalid.", results_checked, invalid_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cidr_pkg.sv
rtl/ipv4_cidr_text_parser.sv
tb/sv/ipv4_cidr_text_parser_tb.sv
